@@ hdl/xrg_pkg.sv @@
// shared types, codes, constants and xorshift functions of the xorwow generator
package xrg_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned OpWidth   = 2;
   localparam int unsigned BitCountWidth = $clog2(WordWidth);

   localparam logic [WordWidth-1:0] SEED_RESET = 32'd1;
   localparam logic [WordWidth-1:0] WEYL_STEP  = 32'd362437;

   // request operation codes
   localparam logic [OpWidth-1:0] OP_RAW    = 2'd0;
   localparam logic [OpWidth-1:0] OP_URANGE = 2'd1;
   localparam logic [OpWidth-1:0] OP_SRANGE = 2'd2;
   localparam logic [OpWidth-1:0] OP_NONE   = 2'd3;

   // control from the sequencer to the remainder unit and back
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
   } div_stat_type;

   // one xorshift32 (13,17,5) step used by the seed chain
   function automatic logic [WordWidth-1:0] chain_step(input logic [WordWidth-1:0] x);
      logic [WordWidth-1:0] v;
      v = x;
      v = v ^ (v << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
   endfunction

   // new xorshift word from the oldest and newest words
   function automatic logic [WordWidth-1:0] mix_word(input logic [WordWidth-1:0] oldest,
                                                     input logic [WordWidth-1:0] newest);
      logic [WordWidth-1:0] t;
      t = oldest;
      t = t ^ (t >> 2);
      t = t ^ (t << 1);
      t = t ^ newest ^ (newest << 4);
      return t;
   endfunction

endpackage

@@ hdl/xrg_state.sv @@
// generator state: seed chain fill and one xorwow step per draw
module xrg_state (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            seed_load,
   input  logic [xrg_pkg::WordWidth-1:0]   seed_value,
   input  logic                            draw,
   output logic                            seeding,
   output logic [xrg_pkg::WordWidth-1:0]   draw_value
);

   logic [xrg_pkg::WordWidth-1:0] word0_ff, word1_ff, word2_ff, word3_ff, weyl_ff;
   logic [xrg_pkg::WordWidth-1:0] draw_ff;
   logic                          seeding_ff;
   logic [1:0]                    seed_idx_ff;
   logic [xrg_pkg::WordWidth-1:0] mixed;
   logic [xrg_pkg::WordWidth-1:0] weyl_in;

   // next xorshift word and weyl counter for a draw
   assign mixed   = xrg_pkg::mix_word(word3_ff, word0_ff);
   assign weyl_in = weyl_ff + xrg_pkg::WEYL_STEP;

   // seeding sequence, one chain word per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         seeding_ff  <= 1'b1;
         seed_idx_ff <= 2'd0;
         word0_ff    <= xrg_pkg::SEED_RESET;
      end else if (seed_load) begin
         seeding_ff  <= 1'b1;
         seed_idx_ff <= 2'd0;
         word0_ff    <= seed_value;
      end else if (seeding_ff) begin
         seed_idx_ff <= seed_idx_ff + 2'd1;
         case (seed_idx_ff)
            2'd0: begin
               word1_ff <= xrg_pkg::chain_step(word0_ff);
            end
            2'd1: begin
               word2_ff <= xrg_pkg::chain_step(word1_ff);
            end
            2'd2: begin
               word3_ff <= xrg_pkg::chain_step(word2_ff);
            end
            default: begin
               weyl_ff    <= xrg_pkg::chain_step(word3_ff);
               seeding_ff <= 1'b0;
            end
         endcase
      end else if (draw) begin
         word3_ff <= word2_ff;
         word2_ff <= word1_ff;
         word1_ff <= word0_ff;
         word0_ff <= mixed;
         weyl_ff  <= weyl_in;
      end
   end

   // registered draw result
   always_ff @(posedge clock) begin
      if (draw && !seeding_ff) begin
         draw_ff <= mixed + weyl_in;
      end
   end

   assign seeding    = seeding_ff;
   assign draw_value = draw_ff;

endmodule

@@ hdl/xrg_modulo.sv @@
// bit-serial remainder unit, one quotient bit per cycle
module xrg_modulo (
   input  logic                            clock,
   input  logic                            reset,
   input  xrg_pkg::div_ctrl_type           ctrl,
   input  logic [xrg_pkg::WordWidth-1:0]   dividend,
   input  logic [xrg_pkg::WordWidth-1:0]   divisor,
   output xrg_pkg::div_stat_type           stat,
   output logic [xrg_pkg::WordWidth-1:0]   remainder
);

   logic [xrg_pkg::WordWidth-1:0]     quot_ff;
   logic [xrg_pkg::WordWidth-1:0]     rem_ff;
   logic [xrg_pkg::WordWidth-1:0]     div_ff;
   logic [xrg_pkg::BitCountWidth-1:0] cnt_ff;
   logic                              busy_ff;
   logic                              done_ff;
   logic [xrg_pkg::WordWidth:0]       trial;
   logic [xrg_pkg::WordWidth:0]       diff;

   // shift one dividend bit into the partial remainder and try a subtract
   assign trial = {rem_ff, quot_ff[xrg_pkg::WordWidth-1]};
   assign diff  = trial - {1'b0, div_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + xrg_pkg::BitCountWidth'(1);
            if (cnt_ff == xrg_pkg::BitCountWidth'(xrg_pkg::WordWidth - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath shift registers
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[xrg_pkg::WordWidth-2:0], 1'b0};
         if (!diff[xrg_pkg::WordWidth]) begin
            rem_ff <= diff[xrg_pkg::WordWidth-1:0];
         end else begin
            rem_ff <= trial[xrg_pkg::WordWidth-1:0];
         end
      end
   end

   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

@@ hdl/xorwow_random_generator_core.sv @@
// top level of the xorwow generator: request sequencer and result register
//
// Xorwow pseudo-random generator with raw, unsigned range and signed range draws.
// After reset or a write to the seed register the state is refilled, and requests
// are stalled while it is. A raw draw is registered in the generator state, then
// in the result register, then in the output register; an empty range (or unused
// operation code) goes straight to the result register, then to the output
// register. A range draw passes through the bit-serial remainder unit, which
// produces one quotient bit per cycle, before its remainder plus the lower bound
// goes to the result register. One request is worked on at a time; a finished
// result sits in the output register while the next request is taken.
module xorwow_random_generator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [xrg_pkg::WordWidth-1:0]   csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [xrg_pkg::OpWidth-1:0]     req_operation,
   input  logic [xrg_pkg::WordWidth-1:0]   req_lower_bound,
   input  logic [xrg_pkg::WordWidth-1:0]   req_upper_bound,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [xrg_pkg::WordWidth-1:0]   rsp_value
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DRAW   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [xrg_pkg::OpWidth-1:0]   op_ff, op_in;
   logic [xrg_pkg::WordWidth-1:0] lower_ff, lower_in;
   logic [xrg_pkg::WordWidth-1:0] modulus_ff, modulus_in;
   logic [xrg_pkg::WordWidth-1:0] result_ff, result_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [xrg_pkg::WordWidth-1:0] rsp_value_ff, rsp_value_in;

   logic                          seeding;
   logic                          draw;
   logic [xrg_pkg::WordWidth-1:0] draw_value;
   xrg_pkg::div_ctrl_type         div_ctrl;
   xrg_pkg::div_stat_type         div_stat;
   logic [xrg_pkg::WordWidth-1:0] remainder;
   logic                          req_xfer;
   logic                          empty_range;

   xrg_state u_state (
      .clock      (clock),
      .reset      (reset),
      .seed_load  (csr_write_enable),
      .seed_value (csr_write_data),
      .draw       (draw),
      .seeding    (seeding),
      .draw_value (draw_value)
   );

   xrg_modulo u_modulo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (draw_value),
      .divisor   (modulus_ff),
      .stat      (div_stat),
      .remainder (remainder)
   );

   assign req_stall = seeding || (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   // ranges that return the lower bound (or zero) without drawing
   always_comb begin
      unique case (req_operation)
         xrg_pkg::OP_RAW:    empty_range = 1'b0;
         xrg_pkg::OP_URANGE: empty_range = (req_upper_bound <= req_lower_bound);
         xrg_pkg::OP_SRANGE: empty_range = (req_upper_bound == req_lower_bound);
         default:            empty_range = 1'b1;
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      lower_in      = lower_ff;
      modulus_in    = modulus_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      draw          = 1'b0;
      div_ctrl.start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in      = req_operation;
               lower_in   = req_lower_bound;
               modulus_in = req_upper_bound - req_lower_bound;
               if (empty_range) begin
                  result_in = (req_operation == xrg_pkg::OP_NONE) ? '0 : req_lower_bound;
                  state_in  = ST_FINISH;
               end else begin
                  draw     = 1'b1;
                  state_in = ST_DRAW;
               end
            end
         end
         ST_DRAW: begin
            if (op_ff == xrg_pkg::OP_RAW) begin
               result_in = draw_value;
               state_in  = ST_FINISH;
            end else begin
               div_ctrl.start = 1'b1;
               state_in       = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               result_in = remainder + lower_ff;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      lower_ff     <= lower_in;
      modulus_ff   <= modulus_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule
